FILE: src/vsam_pkg.sv
package vsam_pkg;

  // Core sizing.
  localparam int DATA_BITS   = 8;
  localparam int COUNT_WIDTH = 32;

  // Percentage arithmetic: quotient bits plus one guard bit for saturation.
  localparam int PCT_SCALE = 100;
  localparam int PCT_W     = 7;
  localparam int QUO_W     = PCT_W + 1;
  localparam int REM_W     = COUNT_WIDTH + PCT_W;
  localparam int DIV_STEPS = QUO_W;
  localparam int STEP_W    = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

  // Result sequencing.
  localparam int SLOT_W = $clog2(DATA_BITS + 1);
  localparam int LANE_W = (DATA_BITS > 1) ? $clog2(DATA_BITS) : 1;

  // Fixed port widths of the result word.
  localparam int OUT_CNT_W  = 32;
  localparam int SLOT_OUT_W = 4;
  localparam int LATEST_W   = 8;
  localparam int LEVELS_W   = 3;

  // Register port.
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = APB_ADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_WINDOW_MODE = '0;

  typedef logic [COUNT_WIDTH-1:0] cnt_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT
  } state_e;

  // Controls broadcast from the sequencer to every lane.
  typedef struct packed {
    logic count_en;
    logic high_en;
    logic clear;
    logic load;
    logic step;
  } lane_ctl_t;

  // Aggregate counts and latest pin values shared by every result word.
  typedef struct packed {
    cnt_t                 pclk_edges;
    cnt_t                 hsync_edges;
    cnt_t                 vsync_edges;
    cnt_t                 data_changes;
    cnt_t                 samples;
    logic [DATA_BITS-1:0] latest_data;
    logic [LEVELS_W-1:0]  latest_levels;
  } agg_t;

endpackage

FILE: src/vsam_lane.sv
module vsam_lane (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  vsam_pkg::lane_ctl_t     ctl_i,
  input  logic                    data_bit_i,
  input  logic                    diff_bit_i,
  input  vsam_pkg::cnt_t          samples_i,
  output vsam_pkg::cnt_t          edges_o,
  output logic [vsam_pkg::PCT_W-1:0] pct_o
);

  vsam_pkg::cnt_t edge_q, edge_d;
  vsam_pkg::cnt_t high_q, high_d;

  logic [vsam_pkg::REM_W-1:0] rem_q, rem_d;
  logic [vsam_pkg::REM_W-1:0] dvs_q, dvs_d;
  logic [vsam_pkg::QUO_W-1:0] quo_q, quo_d;
  logic                       ge;

  // Per-bit change and high counters.
  always_comb begin
    edge_d = edge_q;
    high_d = high_q;
    if (ctl_i.clear) begin
      edge_d = '0;
      high_d = '0;
    end else if (ctl_i.count_en) begin
      edge_d = edge_q + vsam_pkg::cnt_t'(diff_bit_i);
      if (ctl_i.high_en) begin
        high_d = high_q + vsam_pkg::cnt_t'(data_bit_i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edge_q <= '0;
      high_q <= '0;
    end else begin
      edge_q <= edge_d;
      high_q <= high_d;
    end
  end

  // Restoring divider: one quotient bit per step, the top bit flags a quotient of 128 or more.
  assign ge = (rem_q >= dvs_q);

  always_comb begin
    rem_d = rem_q;
    dvs_d = dvs_q;
    quo_d = quo_q;
    if (ctl_i.load) begin
      rem_d = vsam_pkg::REM_W'(high_q) * vsam_pkg::REM_W'(vsam_pkg::PCT_SCALE);
      dvs_d = vsam_pkg::REM_W'(samples_i) << vsam_pkg::PCT_W;
      quo_d = '0;
    end else if (ctl_i.step) begin
      if (ge) begin
        rem_d = rem_q - dvs_q;
      end
      dvs_d = dvs_q >> 1;
      quo_d = {quo_q[vsam_pkg::QUO_W-2:0], ge};
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  assign edges_o = edge_q;
  assign pct_o   = (quo_q > vsam_pkg::QUO_W'(vsam_pkg::PCT_SCALE))
                 ? vsam_pkg::PCT_W'(vsam_pkg::PCT_SCALE)
                 : vsam_pkg::PCT_W'(quo_q);

endmodule

FILE: src/vsam_merge.sv
module vsam_merge (
  input  logic [vsam_pkg::SLOT_W-1:0]   slot_i,
  input  logic                          window_mode_i,
  input  vsam_pkg::agg_t                agg_i,
  input  vsam_pkg::cnt_t                edges_i [vsam_pkg::DATA_BITS],
  input  logic [vsam_pkg::PCT_W-1:0]    pct_i   [vsam_pkg::DATA_BITS],
  output logic [vsam_pkg::SLOT_OUT_W-1:0] result_slot_o,
  output logic [vsam_pkg::OUT_CNT_W-1:0]  pclk_edges_o,
  output logic [vsam_pkg::OUT_CNT_W-1:0]  hsync_edges_o,
  output logic [vsam_pkg::OUT_CNT_W-1:0]  vsync_edges_o,
  output logic [vsam_pkg::OUT_CNT_W-1:0]  data_changes_o,
  output logic [vsam_pkg::OUT_CNT_W-1:0]  samples_seen_o,
  output logic [vsam_pkg::LATEST_W-1:0]   latest_data_o,
  output logic [vsam_pkg::LEVELS_W-1:0]   latest_levels_o,
  output logic [vsam_pkg::PCT_W-1:0]      bit_high_percent_o,
  output logic [vsam_pkg::OUT_CNT_W-1:0]  bit_edges_o,
  output logic                            last_of_report_o
);

  logic [vsam_pkg::SLOT_W-1:0] slot_m1;
  logic [vsam_pkg::LANE_W-1:0] lane_idx;
  logic                        is_agg;

  // Slot zero is the aggregate word; slot k selects lane k-1.
  assign slot_m1  = slot_i - vsam_pkg::SLOT_W'(1);
  assign lane_idx = vsam_pkg::LANE_W'(slot_m1);
  assign is_agg   = (slot_i == '0);

  assign result_slot_o   = vsam_pkg::SLOT_OUT_W'(slot_i);
  assign pclk_edges_o    = vsam_pkg::OUT_CNT_W'(agg_i.pclk_edges);
  assign hsync_edges_o   = vsam_pkg::OUT_CNT_W'(agg_i.hsync_edges);
  assign vsync_edges_o   = vsam_pkg::OUT_CNT_W'(agg_i.vsync_edges);
  assign data_changes_o  = vsam_pkg::OUT_CNT_W'(agg_i.data_changes);
  assign samples_seen_o  = vsam_pkg::OUT_CNT_W'(agg_i.samples);
  assign latest_data_o   = vsam_pkg::LATEST_W'(agg_i.latest_data);
  assign latest_levels_o = agg_i.latest_levels;

  // The percentage is only meaningful in windowed mode with at least one sample.
  always_comb begin
    bit_high_percent_o = '0;
    bit_edges_o        = '0;
    if (!is_agg) begin
      bit_edges_o = vsam_pkg::OUT_CNT_W'(edges_i[lane_idx]);
      if (window_mode_i && (agg_i.samples != '0)) begin
        bit_high_percent_o = pct_i[lane_idx];
      end
    end
  end

  assign last_of_report_o = (slot_i == vsam_pkg::SLOT_W'(vsam_pkg::DATA_BITS));

endmodule

FILE: src/video_signal_activity_monitor.sv
// Pin activity monitor for a parallel video interface. Each input word is
// either a pin sample (pixel clock, hsync and vsync levels plus the data bus)
// or a report request. Pin samples are taken one per clock cycle while no
// report is in progress. A report request closes input until the report is
// delivered: the per-bit high percentages are produced by a restoring divider
// in each data-bit lane, one quotient bit per cycle, after which the DATA_BITS+1
// result words are offered one per cycle as the sink takes them, and the next
// input word is accepted only after the last result word is taken. Counters
// reset to zero and need no clearing pass. The window_mode register sits at
// byte address 0 of the register port and must only be written while the
// block is idle.
module video_signal_activity_monitor (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Register port.
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [vsam_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [vsam_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [vsam_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready,
  // Input words.
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                req_type_i,
  input  logic                                pclk_level_i,
  input  logic                                hsync_level_i,
  input  logic                                vsync_level_i,
  input  logic [vsam_pkg::DATA_BITS-1:0]      data_bus_i,
  // Result words.
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [vsam_pkg::SLOT_OUT_W-1:0]     result_slot_o,
  output logic [vsam_pkg::OUT_CNT_W-1:0]      pclk_edges_o,
  output logic [vsam_pkg::OUT_CNT_W-1:0]      hsync_edges_o,
  output logic [vsam_pkg::OUT_CNT_W-1:0]      vsync_edges_o,
  output logic [vsam_pkg::OUT_CNT_W-1:0]      data_changes_o,
  output logic [vsam_pkg::OUT_CNT_W-1:0]      samples_seen_o,
  output logic [vsam_pkg::LATEST_W-1:0]       latest_data_o,
  output logic [vsam_pkg::LEVELS_W-1:0]       latest_levels_o,
  output logic [vsam_pkg::PCT_W-1:0]          bit_high_percent_o,
  output logic [vsam_pkg::OUT_CNT_W-1:0]      bit_edges_o,
  output logic                                last_of_report_o
);

  vsam_pkg::state_e state_q, state_d;
  logic [vsam_pkg::SLOT_W-1:0] slot_q, slot_d;
  logic [vsam_pkg::STEP_W-1:0] step_q, step_d;

  logic window_mode_q, window_mode_d;
  logic primed_q, primed_d;
  vsam_pkg::agg_t agg_q, agg_d;

  logic in_acc, smp_acc, rpt_acc, out_acc, last_slot, done_clear;
  logic [vsam_pkg::LEVELS_W-1:0]  levels, ldiff;
  logic [vsam_pkg::DATA_BITS-1:0] diff;
  logic reg_sel;

  vsam_pkg::lane_ctl_t lane_ctl;
  vsam_pkg::cnt_t             lane_edges [vsam_pkg::DATA_BITS];
  logic [vsam_pkg::PCT_W-1:0] lane_pct   [vsam_pkg::DATA_BITS];

  // Register port: single control bit, no wait states.
  assign pready  = 1'b1;
  assign reg_sel = (paddr[vsam_pkg::APB_ADDR_W-1:2] == vsam_pkg::REG_WINDOW_MODE);
  assign prdata  = reg_sel ? vsam_pkg::APB_DATA_W'(window_mode_q) : '0;

  always_comb begin
    window_mode_d = window_mode_q;
    if (psel && penable && pwrite && pready && reg_sel) begin
      window_mode_d = pwdata[0];
    end
  end

  // Handshake decode.
  assign in_ready_o  = (state_q == vsam_pkg::ST_IDLE);
  assign out_valid_o = (state_q == vsam_pkg::ST_EMIT);
  assign in_acc      = in_valid_i && in_ready_o;
  assign smp_acc     = in_acc && !req_type_i;
  assign rpt_acc     = in_acc && req_type_i;
  assign out_acc     = out_valid_o && out_ready_i;
  assign last_slot   = (slot_q == vsam_pkg::SLOT_W'(vsam_pkg::DATA_BITS));
  assign done_clear  = out_acc && last_slot && window_mode_q;

  // Sequencer: idle, divide, then walk the result slots.
  always_comb begin
    state_d = state_q;
    slot_d  = slot_q;
    step_d  = step_q;
    case (state_q)
      vsam_pkg::ST_IDLE: begin
        if (rpt_acc) begin
          state_d = vsam_pkg::ST_DIV;
          step_d  = '0;
        end
      end
      vsam_pkg::ST_DIV: begin
        step_d = step_q + vsam_pkg::STEP_W'(1);
        if (step_q == vsam_pkg::STEP_W'(vsam_pkg::DIV_STEPS - 1)) begin
          state_d = vsam_pkg::ST_EMIT;
          slot_d  = '0;
        end
      end
      vsam_pkg::ST_EMIT: begin
        if (out_acc) begin
          if (last_slot) begin
            state_d = vsam_pkg::ST_IDLE;
          end else begin
            slot_d = slot_q + vsam_pkg::SLOT_W'(1);
          end
        end
      end
      default: begin
        state_d = vsam_pkg::ST_IDLE;
      end
    endcase
  end

  // Aggregate counters and the previous pin levels.
  assign levels = {vsync_level_i, hsync_level_i, pclk_level_i};
  assign ldiff  = levels ^ agg_q.latest_levels;
  assign diff   = data_bus_i ^ agg_q.latest_data;

  always_comb begin
    agg_d    = agg_q;
    primed_d = primed_q;
    if (done_clear) begin
      agg_d.pclk_edges   = '0;
      agg_d.hsync_edges  = '0;
      agg_d.vsync_edges  = '0;
      agg_d.data_changes = '0;
      agg_d.samples      = '0;
      primed_d           = 1'b0;
    end else if (smp_acc) begin
      if (primed_q) begin
        agg_d.pclk_edges   = agg_q.pclk_edges + vsam_pkg::cnt_t'(ldiff[0]);
        agg_d.hsync_edges  = agg_q.hsync_edges + vsam_pkg::cnt_t'(ldiff[1]);
        agg_d.vsync_edges  = agg_q.vsync_edges + vsam_pkg::cnt_t'(ldiff[2]);
        agg_d.data_changes = agg_q.data_changes + vsam_pkg::cnt_t'(diff != '0);
      end
      if (!window_mode_q || primed_q) begin
        agg_d.samples = agg_q.samples + vsam_pkg::cnt_t'(1);
      end
      agg_d.latest_levels = levels;
      agg_d.latest_data   = data_bus_i;
      primed_d            = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= vsam_pkg::ST_IDLE;
      slot_q        <= '0;
      step_q        <= '0;
      window_mode_q <= 1'b0;
      primed_q      <= 1'b0;
      agg_q         <= '0;
    end else begin
      state_q       <= state_d;
      slot_q        <= slot_d;
      step_q        <= step_d;
      window_mode_q <= window_mode_d;
      primed_q      <= primed_d;
      agg_q         <= agg_d;
    end
  end

  // One lane per data bit.
  assign lane_ctl.count_en = smp_acc && primed_q;
  assign lane_ctl.high_en  = window_mode_q;
  assign lane_ctl.clear    = done_clear;
  assign lane_ctl.load     = rpt_acc;
  assign lane_ctl.step     = (state_q == vsam_pkg::ST_DIV);

  for (genvar g = 0; g < vsam_pkg::DATA_BITS; g++) begin : g_lane
    vsam_lane u_lane (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (lane_ctl),
      .data_bit_i (data_bus_i[g]),
      .diff_bit_i (diff[g]),
      .samples_i  (agg_q.samples),
      .edges_o    (lane_edges[g]),
      .pct_o      (lane_pct[g])
    );
  end

  // Result word assembly.
  vsam_merge u_merge (
    .slot_i             (slot_q),
    .window_mode_i      (window_mode_q),
    .agg_i              (agg_q),
    .edges_i            (lane_edges),
    .pct_i              (lane_pct),
    .result_slot_o      (result_slot_o),
    .pclk_edges_o       (pclk_edges_o),
    .hsync_edges_o      (hsync_edges_o),
    .vsync_edges_o      (vsync_edges_o),
    .data_changes_o     (data_changes_o),
    .samples_seen_o     (samples_seen_o),
    .latest_data_o      (latest_data_o),
    .latest_levels_o    (latest_levels_o),
    .bit_high_percent_o (bit_high_percent_o),
    .bit_edges_o        (bit_edges_o),
    .last_of_report_o   (last_of_report_o)
  );

endmodule

FILE: src/vsam_checker.sv
module vsam_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_ready_o,
  input logic                                req_type_i,
  input logic                                out_valid_o,
  input logic                                out_ready_i,
  input logic [vsam_pkg::SLOT_OUT_W-1:0]     result_slot_o,
  input logic [vsam_pkg::PCT_W-1:0]          bit_high_percent_o,
  input logic                                last_of_report_o
);

  // A stalled result word keeps its slot.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(result_slot_o))
    else $error("result word changed while stalled");

  // Input is closed while a report is being delivered.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("input open during report");

  // An accepted report request closes the input in the next cycle.
  a_report_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && req_type_i |=> !in_ready_o)
    else $error("input still open after report request");

  // The final word of a report is the one for the highest data bit.
  a_last_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      (last_of_report_o == (result_slot_o ==
        vsam_pkg::SLOT_OUT_W'(vsam_pkg::DATA_BITS))))
    else $error("last marker on wrong slot");

  // A percentage never exceeds full scale.
  a_pct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (bit_high_percent_o <= vsam_pkg::PCT_W'(vsam_pkg::PCT_SCALE)))
    else $error("percentage out of range");

endmodule

bind video_signal_activity_monitor vsam_checker u_vsam_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid_i         (in_valid_i),
  .in_ready_o         (in_ready_o),
  .req_type_i         (req_type_i),
  .out_valid_o        (out_valid_o),
  .out_ready_i        (out_ready_i),
  .result_slot_o      (result_slot_o),
  .bit_high_percent_o (bit_high_percent_o),
  .last_of_report_o   (last_of_report_o)
);
